### design/rfa_pkg.sv
// rfa_pkg: shared constants, codes and beat types of the rgb frame accumulator
// depends on nothing; imported by every rfa module but rfa_ram, and by the top level
`default_nettype none

package rfa_pkg;

   // frame geometry and plane storage
   localparam int MAX_PIXELS = 65536;
   localparam int CHANNELS   = 3;
   localparam int PIX_W      = $clog2(MAX_PIXELS);
   localparam int SIZE_W     = PIX_W + 1;
   localparam int CH_W       = 2;
   localparam int RAM_AW     = CH_W + PIX_W;
   localparam int RAM_DEPTH  = CHANNELS * MAX_PIXELS;

   // field widths
   localparam int SUM_W      = 32;
   localparam int COUNT_W    = 16;
   localparam int FILTER_W   = 4;
   localparam int PPF_W      = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_RED       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_GREEN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_BLUE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_TO_AVG    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENTAL_MODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXELS_PER_FRAME = 3'd5;

   // register reset values
   localparam logic [FILTER_W-1:0] RST_FILTER_RED   = 4'd0;
   localparam logic [FILTER_W-1:0] RST_FILTER_GREEN = 4'd1;
   localparam logic [FILTER_W-1:0] RST_FILTER_BLUE  = 4'd2;
   localparam logic [COUNT_W-1:0]  RST_FRAMES_TO_AVG = 16'd1;
   localparam logic [PPF_W-1:0]    RST_PIXELS_PER_FRAME = 17'd65536;

   // channel codes
   localparam logic [CH_W-1:0] CH_RED     = 2'd0;
   localparam logic [CH_W-1:0] CH_GREEN   = 2'd1;
   localparam logic [CH_W-1:0] CH_BLUE    = 2'd2;
   localparam logic [CH_W-1:0] CH_SKIPPED = 2'd3;

   // queues
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [SUM_W-1:0]    raw_count;
      logic [FILTER_W-1:0] wheel_position;
      logic                clear_request;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [SUM_W-1:0]   summed_value;
      logic               saturated;
      logic               frame_done;
      logic [COUNT_W-1:0] channel_frames;
      logic [SUM_W-1:0]   frame_maximum;
      logic               planes_cleared;
   } rsp_type;

   // classified pixel handed from the front to the back
   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [PIX_W-1:0]   pixel_index;
      logic [SUM_W-1:0]   raw_count;
      logic               frame_start;
      logic               plane_clear;
      logic               frame_done;
      logic [COUNT_W-1:0] channel_frames;
      logic               planes_cleared;
   } cmd_type;

endpackage

`default_nettype wire

### design/rfa_ram.sv
// rfa_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module rfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/rfa_front.sv
// rfa_front: configuration registers, frame tracking and clear decision
// depends on rfa_pkg; classifies each accepted pixel into a cmd_type beat
`default_nettype none

module rfa_front import rfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  cmd_push,
   output cmd_type               cmd_data,
   input  logic                  cmd_full
);

   // configuration
   logic [FILTER_W-1:0] filter_ff [CHANNELS];
   logic [FILTER_W-1:0] filter_in [CHANNELS];
   logic [COUNT_W-1:0]  fta_ff, fta_in;
   logic                incr_ff, incr_in;
   logic [PPF_W-1:0]    ppf_ff, ppf_in;

   // frame state
   logic [PIX_W-1:0]    pixel_ff, pixel_in;
   logic [CH_W-1:0]     channel_ff, channel_in;
   logic                clear_seen_ff, clear_seen_in;
   logic [SIZE_W-1:0]   plane_size_ff, plane_size_in;
   logic [COUNT_W-1:0]  counts_ff [CHANNELS];
   logic [COUNT_W-1:0]  counts_in [CHANNELS];
   logic [FILTER_W-1:0] used_filter_ff [CHANNELS];
   logic [FILTER_W-1:0] used_filter_in [CHANNELS];

   logic                accept;
   logic                first;
   logic [SIZE_W-1:0]   size;
   logic [COUNT_W-1:0]  need;
   logic                all_met;
   logic                stale;
   logic                start_clear;
   logic [CH_W-1:0]     match;
   logic [CH_W-1:0]     ch;
   logic                cleared;
   logic                done;
   logic [COUNT_W-1:0]  counts_next [CHANNELS];
   logic [COUNT_W-1:0]  frames;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push & ~cmd_full;

   always_comb begin
      filter_in = filter_ff;
      fta_in    = fta_ff;
      incr_in   = incr_ff;
      ppf_in    = ppf_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_RED:       filter_in[CH_RED]   = csr_wdata[FILTER_W-1:0];
            CSR_FILTER_GREEN:     filter_in[CH_GREEN] = csr_wdata[FILTER_W-1:0];
            CSR_FILTER_BLUE:      filter_in[CH_BLUE]  = csr_wdata[FILTER_W-1:0];
            CSR_FRAMES_TO_AVG:    fta_in  = csr_wdata[COUNT_W-1:0];
            CSR_INCREMENTAL_MODE: incr_in = csr_wdata[0];
            CSR_PIXELS_PER_FRAME: ppf_in  = csr_wdata[PPF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      first = (pixel_ff == '0);

      // frame size clamped to one .. max pixels
      if (ppf_ff == '0) begin
         size = SIZE_W'(1);
      end else if (int'(ppf_ff) > MAX_PIXELS) begin
         size = SIZE_W'(MAX_PIXELS);
      end else begin
         size = SIZE_W'(ppf_ff);
      end

      need = (fta_ff == '0) ? COUNT_W'(1) : fta_ff;

      all_met = 1'b1;
      stale   = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (counts_ff[i] < need) begin
            all_met = 1'b0;
         end
         if (counts_ff[i] != '0 && used_filter_ff[i] != filter_ff[i]) begin
            stale = 1'b1;
         end
      end
      start_clear = req_data.clear_request | (~incr_ff & all_met)
                  | (plane_size_ff != size) | stale;

      // lowest channel wins on duplicate filter indices
      match = CH_SKIPPED;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (filter_ff[i] == req_data.wheel_position) begin
            match = CH_W'(i);
         end
      end

      ch      = first ? match : channel_ff;
      cleared = first ? start_clear : clear_seen_ff;
      done    = (SIZE_W'(pixel_ff) + SIZE_W'(1)) >= size;

      frames = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         counts_next[i] = (first && start_clear) ? '0 : counts_ff[i];
         if (done && ch == CH_W'(i) && counts_next[i] != '1) begin
            counts_next[i] = counts_next[i] + COUNT_W'(1);
         end
         if (done && ch == CH_W'(i)) begin
            frames = counts_next[i];
         end
      end

      pixel_in       = pixel_ff;
      channel_in     = channel_ff;
      clear_seen_in  = clear_seen_ff;
      plane_size_in  = plane_size_ff;
      counts_in      = counts_ff;
      used_filter_in = used_filter_ff;
      if (accept) begin
         pixel_in  = done ? '0 : pixel_ff + PIX_W'(1);
         counts_in = counts_next;
         if (first) begin
            channel_in    = match;
            clear_seen_in = start_clear;
            plane_size_in = size;
            for (int i = 0; i < CHANNELS; i++) begin
               if (match == CH_W'(i)) begin
                  used_filter_in[i] = filter_ff[i];
               end
            end
         end
      end

      cmd_push                = accept;
      cmd_data.channel        = ch;
      cmd_data.pixel_index    = pixel_ff;
      cmd_data.raw_count      = req_data.raw_count;
      cmd_data.frame_start    = first;
      cmd_data.plane_clear    = first & start_clear;
      cmd_data.frame_done     = done;
      cmd_data.channel_frames = frames;
      cmd_data.planes_cleared = cleared;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff[CH_RED]   <= RST_FILTER_RED;
         filter_ff[CH_GREEN] <= RST_FILTER_GREEN;
         filter_ff[CH_BLUE]  <= RST_FILTER_BLUE;
         fta_ff         <= RST_FRAMES_TO_AVG;
         incr_ff        <= 1'b0;
         ppf_ff         <= RST_PIXELS_PER_FRAME;
         pixel_ff       <= '0;
         channel_ff     <= '0;
         clear_seen_ff  <= 1'b0;
         plane_size_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            counts_ff[i]      <= '0;
            used_filter_ff[i] <= '0;
         end
      end else begin
         filter_ff      <= filter_in;
         fta_ff         <= fta_in;
         incr_ff        <= incr_in;
         ppf_ff         <= ppf_in;
         pixel_ff       <= pixel_in;
         channel_ff     <= channel_in;
         clear_seen_ff  <= clear_seen_in;
         plane_size_ff  <= plane_size_in;
         counts_ff      <= counts_in;
         used_filter_ff <= used_filter_in;
      end
   end

endmodule

`default_nettype wire

### design/rfa_cmd_queue.sv
// rfa_cmd_queue: small fifo of classified pixels between front and back
// depends on rfa_pkg
`default_nettype none

module rfa_cmd_queue import rfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/rfa_rsp_queue.sv
// rfa_rsp_queue: result fifo in front of the rsp_ ports, reports its fill level
// depends on rfa_pkg
`default_nettype none

module rfa_rsp_queue import rfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              push_data,
   output logic [RSP_CNT_W-1:0] count,
   input  logic                 pop,
   output logic                 empty,
   output rsp_type              head
);

   rsp_type              slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign count   = count_ff;
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & (count_ff != RSP_CNT_W'(RSP_DEPTH));
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/rfa_back.sv
// rfa_back: sum plane read-add-write pipeline and frame maximum
// depends on rfa_pkg and rfa_ram; feeds rfa_rsp_queue with credit flow control
`default_nettype none

module rfa_back import rfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd_head,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   output logic                 rsp_push,
   output rsp_type              rsp_data,
   input  logic [RSP_CNT_W-1:0] rsp_count
);

   // stage b: ram data arrives, add and write back
   logic               b_valid_ff, b_valid_in;
   cmd_type            b_cmd_ff;
   // stage c: running maximum and result
   logic               c_valid_ff, c_valid_in;
   cmd_type            c_cmd_ff;
   logic [SUM_W-1:0]   c_value_ff;
   logic               c_sat_ff;
   // filled prefix of each plane since the last clear
   logic [SIZE_W-1:0]  fill_ff [CHANNELS];
   logic [SIZE_W-1:0]  fill_in [CHANNELS];
   // last write, forwarded past the ram read-during-write
   logic               lw_valid_ff, lw_valid_in;
   logic [RAM_AW-1:0]  lw_addr_ff, lw_addr_in;
   logic [SUM_W-1:0]   lw_data_ff, lw_data_in;
   logic [SUM_W-1:0]   rmax_ff, rmax_in;

   logic [RSP_CNT_W:0] in_flight;
   logic               issue;
   logic [RAM_AW-1:0]  rd_addr;
   logic [SUM_W-1:0]   ram_q;
   logic               b_write;
   logic [RAM_AW-1:0]  b_addr;
   logic [SIZE_W-1:0]  fill_sel;
   logic [SIZE_W-1:0]  idx_next;
   logic [SUM_W-1:0]   old_value;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   b_value;
   logic               b_sat;
   logic [SUM_W-1:0]   max_new;

   assign in_flight = (RSP_CNT_W + 1)'(rsp_count) + (RSP_CNT_W + 1)'(b_valid_ff)
                    + (RSP_CNT_W + 1)'(c_valid_ff);
   assign issue     = ~cmd_empty & (in_flight < (RSP_CNT_W + 1)'(RSP_DEPTH));
   assign cmd_pop   = issue;

   assign rd_addr = (cmd_head.channel == CH_SKIPPED) ? '0
                  : {cmd_head.channel, cmd_head.pixel_index};
   assign b_write = b_valid_ff & (b_cmd_ff.channel != CH_SKIPPED);
   assign b_addr  = {b_cmd_ff.channel, b_cmd_ff.pixel_index};

   rfa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (RAM_DEPTH)
   ) u_planes (
      .clock   (clock),
      .wr_en   (b_write),
      .wr_addr (b_addr),
      .wr_data (b_value),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      fill_sel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (b_cmd_ff.channel == CH_W'(i)) begin
            fill_sel = fill_ff[i];
         end
      end
      idx_next = SIZE_W'(b_cmd_ff.pixel_index) + SIZE_W'(1);

      // entries beyond the filled prefix read as zero
      if (b_cmd_ff.plane_clear) begin
         old_value = '0;
      end else if (lw_valid_ff && lw_addr_ff == b_addr) begin
         old_value = lw_data_ff;
      end else if (SIZE_W'(b_cmd_ff.pixel_index) < fill_sel) begin
         old_value = ram_q;
      end else begin
         old_value = '0;
      end

      sum_wide = {1'b0, old_value} + {1'b0, b_cmd_ff.raw_count};
      if (b_cmd_ff.channel == CH_SKIPPED) begin
         b_value = '0;
         b_sat   = 1'b0;
      end else begin
         b_sat   = sum_wide[SUM_W];
         b_value = b_sat ? '1 : sum_wide[SUM_W-1:0];
      end

      for (int i = 0; i < CHANNELS; i++) begin
         fill_in[i] = fill_ff[i];
         if (b_valid_ff && b_cmd_ff.plane_clear) begin
            fill_in[i] = '0;
         end
         if (b_write && b_cmd_ff.channel == CH_W'(i) && idx_next > fill_in[i]) begin
            fill_in[i] = idx_next;
         end
      end

      lw_valid_in = lw_valid_ff;
      lw_addr_in  = lw_addr_ff;
      lw_data_in  = lw_data_ff;
      if (b_write) begin
         lw_valid_in = 1'b1;
         lw_addr_in  = b_addr;
         lw_data_in  = b_value;
      end else if (b_valid_ff && b_cmd_ff.plane_clear) begin
         lw_valid_in = 1'b0;
      end

      b_valid_in = issue;
      c_valid_in = b_valid_ff;

      if (c_cmd_ff.frame_start || c_value_ff > rmax_ff) begin
         max_new = c_value_ff;
      end else begin
         max_new = rmax_ff;
      end
      rmax_in = c_valid_ff ? max_new : rmax_ff;

      rsp_push                = c_valid_ff;
      rsp_data.channel        = c_cmd_ff.channel;
      rsp_data.summed_value   = c_value_ff;
      rsp_data.saturated      = c_sat_ff;
      rsp_data.frame_done     = c_cmd_ff.frame_done;
      rsp_data.channel_frames = c_cmd_ff.channel_frames;
      rsp_data.frame_maximum  = c_cmd_ff.frame_done ? max_new : '0;
      rsp_data.planes_cleared = c_cmd_ff.planes_cleared;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_cmd_ff <= cmd_head;
      end
      if (b_valid_ff) begin
         c_cmd_ff   <= b_cmd_ff;
         c_value_ff <= b_value;
         c_sat_ff   <= b_sat;
      end
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         lw_valid_ff <= 1'b0;
         rmax_ff     <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         b_valid_ff  <= b_valid_in;
         c_valid_ff  <= c_valid_in;
         lw_valid_ff <= lw_valid_in;
         rmax_ff     <= rmax_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

`default_nettype wire

### design/rgb_frame_accumulator.sv
// rgb_frame_accumulator: top level of the saturating rgb frame accumulator
// depends on rfa_pkg, rfa_front, rfa_cmd_queue, rfa_back, rfa_rsp_queue
//
//   channel   direction  handshake              beat
//   req_      in         req_push / req_full    req_type: raw count, wheel, clear
//   rsp_      out        rsp_pop / rsp_empty    rsp_type: channel, sum, frame stats
//   csr_      in         csr_valid / csr_ready  register index and write data
//
// one pixel beat per cycle sustained while neither queue holds it back; a result
// shows on rsp_ after its pixel passes queue, ram read, add and write, frame maximum
// the rate is set by the single read-add-write pass through the sum plane ram
// reset is synchronous; the planes are never swept, each plane keeps a filled
// prefix count and entries past it read as zero, so no clearing pass is needed
// req_full rises when the four-deep pixel queue fills; the back stops taking
// pixels while the eight-deep result queue plus the pipeline would overflow
`default_nettype none

module rgb_frame_accumulator import rfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // pixel beats in
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   // result beats out
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // front to back queue
   logic    cmd_push;
   cmd_type cmd_in_data;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_head;

   // back to result queue
   logic                 res_push;
   rsp_type              res_data;
   logic [RSP_CNT_W-1:0] res_count;

   // config registers, frame tracking, clear decision, channel match
   rfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data),
      .cmd_full  (cmd_full)
   );

   // decouples pixel intake from the plane pipeline
   rfa_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   // sum planes: read, saturating add, write back, running maximum
   rfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (res_push),
      .rsp_data  (res_data),
      .rsp_count (res_count)
   );

   // finished results wait here until popped
   rfa_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .count     (res_count),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_data)
   );

endmodule

`default_nettype wire
